// File: design/sfcd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfcd_pkg
// Shared types and constants for the sync-word frame checksum deframer.
// ----------------------------------------------------------------------------
package sfcd_pkg;

    localparam int FRAME_LEN_DEF = 95;

    localparam logic [7:0]  SYNC_B0    = 8'h66;  // 'f'
    localparam logic [7:0]  SYNC_B1    = 8'h6D;  // 'm'
    localparam logic [7:0]  SYNC_B2    = 8'h69;  // 'i'
    localparam logic [7:0]  SYNC_LAST  = 8'h67;  // 'g'
    localparam logic [23:0] SYNC_PREFIX = {SYNC_B0, SYNC_B1, SYNC_B2};
    localparam logic [15:0] SYNC_SUM   = 16'(SYNC_B0) + 16'(SYNC_B1)
                                       + 16'(SYNC_B2) + 16'(SYNC_LAST);
    localparam logic [7:0]  TRAIL_E    = 8'h65;  // 'e'
    localparam logic [7:0]  TRAIL_D    = 8'h64;  // 'd'
    localparam logic [6:0]  FIRST_POS  = 7'd4;

    typedef enum logic [1:0] {
        ST_HUNT  = 2'b01,
        ST_FRAME = 2'b10
    } t_mode;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic [6:0] byte_offset;
        logic       last_of_frame;
        logic       frame_good;
    } t_result;

    typedef struct packed {
        logic    emit;
        t_result res;
    } t_eng_out;

endpackage
`default_nettype wire

// File: design/sfcd_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfcd_engine
// Sync hunt, frame position tracking and checksum/trailer check, one word
// per step.
// ----------------------------------------------------------------------------
module sfcd_engine
    import sfcd_pkg::*;
#(
    parameter int FRAME_LEN = FRAME_LEN_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_byte,
    output t_eng_out        o_eng
);

    localparam logic [6:0] POS_CK_LO = 7'(FRAME_LEN - 4);
    localparam logic [6:0] POS_CK_HI = 7'(FRAME_LEN - 3);
    localparam logic [6:0] POS_TR_E  = 7'(FRAME_LEN - 2);
    localparam logic [6:0] POS_LAST  = 7'(FRAME_LEN - 1);

    t_mode       r_mode, n_mode;
    logic [23:0] r_recent, n_recent;
    logic [6:0]  r_pos, n_pos;
    logic [15:0] r_sum, n_sum;
    logic [7:0]  r_ck_lo, n_ck_lo;
    logic        r_tr_ok, n_tr_ok;
    logic        w_last;

    assign w_last = (r_pos >= POS_LAST);

    always_comb begin
        o_eng.emit                  = (r_mode == ST_FRAME);
        o_eng.res.frame_byte        = i_byte;
        o_eng.res.byte_offset       = r_pos;
        o_eng.res.last_of_frame     = w_last;
        o_eng.res.frame_good        = w_last && (r_sum == 16'd0) && r_tr_ok
                                      && (i_byte == TRAIL_D);
    end

    always_comb begin
        n_mode   = r_mode;
        n_recent = r_recent;
        n_pos    = r_pos;
        n_sum    = r_sum;
        n_ck_lo  = r_ck_lo;
        n_tr_ok  = r_tr_ok;
        case (r_mode)
            ST_FRAME: begin
                if (r_pos < POS_CK_LO) begin
                    n_sum = r_sum + 16'(i_byte);
                end else if (r_pos == POS_CK_LO) begin
                    n_ck_lo = i_byte;
                end else if (r_pos == POS_CK_HI) begin
                    // zero exactly when stored word matches the sum
                    n_sum = r_sum ^ {i_byte, r_ck_lo};
                end else if (r_pos == POS_TR_E) begin
                    n_tr_ok = (i_byte == TRAIL_E);
                end
                if (w_last) begin
                    n_mode   = ST_HUNT;
                    n_pos    = 7'd0;
                    n_recent = 24'd0;
                end else begin
                    n_pos = r_pos + 7'd1;
                end
            end
            default: begin
                if (r_recent == SYNC_PREFIX && i_byte == SYNC_LAST) begin
                    n_mode   = ST_FRAME;
                    n_pos    = FIRST_POS;
                    n_sum    = SYNC_SUM;
                    n_ck_lo  = 8'd0;
                    n_tr_ok  = 1'b0;
                    n_recent = 24'd0;
                end else begin
                    n_recent = {r_recent[15:0], i_byte};
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= ST_HUNT;
            r_recent <= 24'd0;
            r_pos    <= 7'd0;
            r_sum    <= 16'd0;
            r_ck_lo  <= 8'd0;
            r_tr_ok  <= 1'b0;
        end else if (i_step) begin
            r_mode   <= n_mode;
            r_recent <= n_recent;
            r_pos    <= n_pos;
            r_sum    <= n_sum;
            r_ck_lo  <= n_ck_lo;
            r_tr_ok  <= n_tr_ok;
        end
    end

endmodule
`default_nettype wire

// File: design/sync_frame_checksum_deframer_core.sv
`default_nettype none
// A frame word accepted into the input register shows its result at o_valid once it
// moves into the result register. Throughput: one word per cycle while the result slot
// is free or being taken; hunting words yield no result and pass even while a result waits downstream.
// The input register and the result register each take one word; the sync,
// position and checksum update sits combinationally between them.
// Reset (synchronous, active low) empties both registers and returns to hunting.
// ----------------------------------------------------------------------------
// sync_frame_checksum_deframer_core
// Byte stream deframer: hunts for the sync word, emits frame bytes with their
// offset and flags the last byte good on checksum and trailer match.
// ----------------------------------------------------------------------------
module sync_frame_checksum_deframer_core
    import sfcd_pkg::*;
#(
    parameter int FRAME_LEN = FRAME_LEN_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_frame_byte,
    output logic [6:0]      o_byte_offset,
    output logic            o_last_of_frame,
    output logic            o_frame_good
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_res;
    t_eng_out   w_eng;
    logic       w_move;

    // the held word moves on unless it needs the result slot and that is blocked
    assign w_move  = r_in_valid && (!w_eng.emit || !r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_move;

    sfcd_engine #(
        .FRAME_LEN (FRAME_LEN)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_move),
        .i_byte  (r_in_byte),
        .o_eng   (w_eng)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_move && w_eng.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_rx_byte;
        end
        if (w_move && w_eng.emit) begin
            r_res <= w_eng.res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_frame_byte    = r_res.frame_byte;
    assign o_byte_offset   = r_res.byte_offset;
    assign o_last_of_frame = r_res.last_of_frame;
    assign o_frame_good    = r_res.frame_good;

    a_good_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_good |-> o_last_of_frame)
        else $error("frame_good raised off the last word");

    a_offset_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_byte_offset >= FIRST_POS)
                    && (o_byte_offset <= 7'(FRAME_LEN - 1)))
        else $error("byte offset outside frame body");

    a_last_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_of_frame == (o_byte_offset == 7'(FRAME_LEN - 1))))
        else $error("last flag does not match offset");

    a_blocked_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && w_eng.emit && r_out_valid && !i_ready |=> r_in_valid)
        else $error("held word lost while result slot blocked");

endmodule
`default_nettype wire

// File: bench/deframe_check_pkg.sv
// ----------------------------------------------------------------------------
// deframe_check_pkg
// Frame tracker and result scoreboard for the sync-word deframer bench: it
// follows the byte stream, predicts every frame word and checks the block's
// output words in order against that prediction.
// ----------------------------------------------------------------------------
package deframe_check_pkg;

    import sfcd_pkg::*;

    localparam int FRAME_LEN = FRAME_LEN_DEF;

    typedef enum int {
        FK_GOOD,
        FK_BAD_SUM,
        FK_BAD_E,
        FK_BAD_D,
        FK_INNER_SYNC,
        FK_TAIL_PREFIX
    } t_frame_kind;

    localparam int FK_COUNT = 6;

    class deframe_scoreboard;

        int unsigned errors;
        int unsigned words_in;
        int unsigned words_checked;
        int unsigned good_frames;
        int unsigned bad_frames;

        t_mode       mode;
        logic [23:0] recent;
        logic [6:0]  next_pos;
        logic [15:0] sum;
        logic [7:0]  stored_low;
        logic        trail_ok;
        t_result     expected_q[$];

        function new();
            mode       = ST_HUNT;
            recent     = '0;
            next_pos   = '0;
            sum        = '0;
            stored_low = '0;
            trail_ok   = 1'b0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Advance the frame tracker by one accepted byte.
        function void note_byte(logic [7:0] b);
            t_result r;
            logic [6:0] at;
            words_in++;
            if (mode == ST_HUNT) begin
                if (recent == SYNC_PREFIX && b == SYNC_LAST) begin
                    mode       = ST_FRAME;
                    next_pos   = FIRST_POS;
                    sum        = SYNC_SUM;
                    stored_low = '0;
                    trail_ok   = 1'b0;
                    recent     = '0;
                end else begin
                    recent = {recent[15:0], b};
                end
                return;
            end
            at = next_pos;
            if (at < FRAME_LEN - 4) begin
                sum = sum + 16'(b);
            end else if (at == FRAME_LEN - 4) begin
                stored_low = b;
            end else if (at == FRAME_LEN - 3) begin
                // zero afterwards exactly when the stored word matches
                sum = sum ^ {b, stored_low};
            end else if (at == FRAME_LEN - 2) begin
                trail_ok = (b == TRAIL_E);
            end
            r.frame_byte    = b;
            r.byte_offset   = at;
            r.last_of_frame = (at >= FRAME_LEN - 1);
            r.frame_good    = 1'b0;
            if (r.last_of_frame) begin
                r.frame_good = (sum == 16'd0) && trail_ok && (b == TRAIL_D);
                mode     = ST_HUNT;
                next_pos = '0;
                recent   = '0;
            end else begin
                next_pos = at + 7'd1;
            end
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 30)
                $display("mismatch: %s", msg);
        endtask

        task check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                report($sformatf("word with nothing expected: byte %02h offset %0d",
                                 got.frame_byte, got.byte_offset));
                return;
            end
            want = expected_q.pop_front();
            words_checked++;
            if (got.frame_byte !== want.frame_byte)
                report($sformatf("frame_byte %02h, want %02h at offset %0d",
                                 got.frame_byte, want.frame_byte, want.byte_offset));
            if (got.byte_offset !== want.byte_offset)
                report($sformatf("byte_offset %0d, want %0d",
                                 got.byte_offset, want.byte_offset));
            if (got.last_of_frame !== want.last_of_frame)
                report($sformatf("last_of_frame %b, want %b at offset %0d",
                                 got.last_of_frame, want.last_of_frame,
                                 want.byte_offset));
            if (got.frame_good !== want.frame_good)
                report($sformatf("frame_good %b, want %b at offset %0d",
                                 got.frame_good, want.frame_good, want.byte_offset));
            if (want.last_of_frame) begin
                if (want.frame_good)
                    good_frames++;
                else
                    bad_frames++;
            end
        endtask

    endclass

endpackage

// File: bench/sync_frame_checksum_deframer_core_test.sv
// ----------------------------------------------------------------------------
// sync_frame_checksum_deframer_core_test
// Streams hunting noise and whole frames (good, bad checksum, bad trailer,
// sync inside the frame, sync prefix at the frame tail) through the deframer
// under random sender and receiver stalls, then stall-free; every output word is checked
// against a tracked prediction of the frame state.
// ----------------------------------------------------------------------------
module sync_frame_checksum_deframer_core_test;

    import sfcd_pkg::*;
    import deframe_check_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic       i_clk;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic [7:0] i_rx_byte = 8'h00;
    logic       i_ready   = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_frame_byte;
    logic [6:0] o_byte_offset;
    logic       o_last_of_frame;
    logic       o_frame_good;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int unsigned cycles = 0;

    deframe_scoreboard sb;

    sync_frame_checksum_deframer_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_frame_byte   (o_frame_byte),
        .o_byte_offset  (o_byte_offset),
        .o_last_of_frame(o_last_of_frame),
        .o_frame_good   (o_frame_good)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Words moved at this edge, sampled before any update of the edge lands.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                sb.note_byte(i_rx_byte);
            if (o_valid && i_ready)
                sb.check_result(t_result'({o_frame_byte, o_byte_offset,
                                           o_last_of_frame, o_frame_good}));
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
    endtask

    task automatic send_frame(input t_frame_kind kind);
        logic [7:0]  fr [FRAME_LEN];
        logic [15:0] total;
        int fill;
        int at;
        int n;
        fill = $urandom_range(7);
        n = $urandom_range(5);
        // hunting noise, biased towards sync letters
        repeat (n) begin
            case ($urandom_range(4))
                0: send_byte(8'($urandom_range(255)));
                1: send_byte(SYNC_B0);
                2: send_byte(SYNC_B1);
                3: send_byte(SYNC_B2);
                default: send_byte(SYNC_LAST);
            endcase
        end
        fr[0] = SYNC_B0;
        fr[1] = SYNC_B1;
        fr[2] = SYNC_B2;
        fr[3] = SYNC_LAST;
        for (at = 4; at < FRAME_LEN - 4; at++) begin
            case (fill)
                0: fr[at] = 8'hFF;
                1: fr[at] = 8'h00;
                2: fr[at] = ($urandom_range(1) != 0) ? SYNC_B0 : SYNC_LAST;
                default: fr[at] = 8'($urandom_range(255));
            endcase
        end
        if (kind == FK_INNER_SYNC) begin
            at = $urandom_range(4, FRAME_LEN - 8);
            fr[at]     = SYNC_B0;
            fr[at + 1] = SYNC_B1;
            fr[at + 2] = SYNC_B2;
            fr[at + 3] = SYNC_LAST;
        end
        total = '0;
        for (at = 0; at < FRAME_LEN - 4; at++)
            total = total + 16'(fr[at]);
        fr[FRAME_LEN - 4] = total[7:0];
        fr[FRAME_LEN - 3] = total[15:8];
        fr[FRAME_LEN - 2] = TRAIL_E;
        fr[FRAME_LEN - 1] = TRAIL_D;
        case (kind)
            FK_BAD_SUM:
                fr[FRAME_LEN - 4 + $urandom_range(1)] ^= 8'(1 << $urandom_range(7));
            FK_BAD_E:
                fr[FRAME_LEN - 2] ^= 8'($urandom_range(1, 255));
            FK_BAD_D:
                fr[FRAME_LEN - 1] ^= 8'($urandom_range(1, 255));
            FK_INNER_SYNC:
                if ($urandom_range(1) != 0)
                    fr[FRAME_LEN - 1] = ~TRAIL_D;
            FK_TAIL_PREFIX: begin
                fr[FRAME_LEN - 3] = SYNC_B0;
                fr[FRAME_LEN - 2] = SYNC_B1;
                fr[FRAME_LEN - 1] = SYNC_B2;
            end
            default: ;
        endcase
        for (at = 0; at < FRAME_LEN; at++)
            send_byte(fr[at]);
        // history is cleared at frame end, so this 'g' must not sync
        if (kind == FK_TAIL_PREFIX)
            send_byte(SYNC_LAST);
    endtask

    initial begin
        logic [7:0] opening [];
        int idx;
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // hunting extremes, broken and misplaced sync, then a doubled lead-in
        opening = '{8'h00, 8'hFF, SYNC_B0, SYNC_B1, SYNC_B2, 8'h00,
                    SYNC_B1, SYNC_B2, SYNC_LAST, SYNC_B0, SYNC_B1, SYNC_LAST,
                    SYNC_LAST, SYNC_B0, SYNC_B0, SYNC_B1, SYNC_B2};
        tx_idle_pct = 25;
        rx_idle_pct = 75;
        foreach (opening[k])
            send_byte(opening[k]);

        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 75 : 0;
            rx_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 25 : 0;
            if (phase == 1) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (sb.pending() != 0)
                    @(posedge i_clk);
            end
            for (int k = 0; k < 5; k++) begin
                idx = phase * 5 + k;
                if (idx < FK_COUNT)
                    send_frame(t_frame_kind'(idx));
                else if ($urandom_range(1) != 0)
                    send_frame(FK_GOOD);
                else
                    send_frame(t_frame_kind'($urandom_range(FK_COUNT - 1)));
            end
        end

        i_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("covered %0d bytes in, %0d frame words checked, %0d good / %0d rejected frames",
                 sb.words_in, sb.words_checked, sb.good_frames, sb.bad_frames);
        $display("under sender-heavy, receiver-heavy and stall-free traffic, %0d mismatches",
                 sb.errors);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: filelist.f
design/sfcd_pkg.sv
design/sfcd_engine.sv
design/sync_frame_checksum_deframer_core.sv
bench/deframe_check_pkg.sv
bench/sync_frame_checksum_deframer_core_test.sv
